@@ hdl/lrupr_pkg.sv @@
package lrupr_pkg;

    // Field widths fixed by the interface
    localparam int PAGE_W = 16;
    localparam int CNT_W  = 32;
    localparam int CFG_W  = 5;

    // Frame count register after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Saturation limit of both totals
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // One entry of the recency stack
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
    } t_entry;

    // Per-cell control from the top level
    typedef struct packed {
        logic load;    // an item is accepted this cycle
        logic active;  // cell position is below the active frame count
        logic drop;    // frame count write puts this cell out of range
    } t_cell_ctl;

endpackage

@@ hdl/lrupr_cell.sv @@
module lrupr_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lrupr_pkg::t_cell_ctl      i_ctl,
    input  logic [lrupr_pkg::PAGE_W-1:0] i_page,
    input  lrupr_pkg::t_entry         i_prev,
    input  logic                      i_above,
    output lrupr_pkg::t_entry         o_entry,
    output logic                      o_above
);

    logic                         r_valid;
    logic [lrupr_pkg::PAGE_W-1:0] r_page;
    logic                         w_match;
    logic                         w_shift;

    // Compare against the referenced page; pass "no match yet" down the row
    assign w_match = r_valid && (r_page == i_page) && i_ctl.active;
    assign o_above = i_above && !w_match;

    // Every active cell at or above the first match (every active cell on a miss) takes its neighbor's entry
    assign w_shift = i_ctl.load && i_above && i_ctl.active;

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_prev.valid;
        end else if (i_ctl.drop) begin
            r_valid <= 1'b0;
        end
    end

    // Page number
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_page <= i_prev.page;
        end
    end

    assign o_entry.valid = r_valid;
    assign o_entry.page  = r_page;

endmodule

@@ hdl/lru_page_replacement.sv @@
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_page_number
// result    out        o_valid / i_stall   o_was_hit, o_hit_total, o_miss_total
// config    in         i_cfg_we            i_cfg_data
//
// One item per cycle while the input is not stalled; the result appears in the cycle after the item is taken.
// The cycle is set by the match chain that runs through the row of FRAMES cells.
// Reset is synchronous: valid bits and totals clear, and the frame count
// returns to 16 (or FRAMES when that is smaller).
// The input stalls only while a result is held and the output is stalled.
module lru_page_replacement #(
    parameter int FRAMES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [lrupr_pkg::PAGE_W-1:0]  i_page_number,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_was_hit,
    output logic [lrupr_pkg::CNT_W-1:0]   o_hit_total,
    output logic [lrupr_pkg::CNT_W-1:0]   o_miss_total,
    input  logic                          i_cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int LIM_W = $clog2(FRAMES + 1);

    logic [LIM_W-1:0]              r_lim;
    logic [LIM_W-1:0]              n_lim;
    logic [LIM_W-1:0]              w_reset_lim;
    logic                          r_valid;
    logic                          r_was_hit;
    logic [lrupr_pkg::CNT_W-1:0]   r_hits;
    logic [lrupr_pkg::CNT_W-1:0]   r_misses;
    logic                          w_accept;
    logic                          w_hit;
    lrupr_pkg::t_entry             w_entry [FRAMES];
    lrupr_pkg::t_entry             w_prev  [FRAMES];
    logic [FRAMES:0]               w_above;
    lrupr_pkg::t_cell_ctl          w_ctl   [FRAMES];

    // Clamp a frame count write into 1..FRAMES, and the reset frame count to FRAMES
    always_comb begin
        if (i_cfg_data == '0) begin
            n_lim = LIM_W'(1);
        end else if (32'(i_cfg_data) > 32'(FRAMES)) begin
            n_lim = LIM_W'(FRAMES);
        end else begin
            n_lim = LIM_W'(i_cfg_data);
        end
        if (32'(lrupr_pkg::CFG_RESET) > 32'(FRAMES)) begin
            w_reset_lim = LIM_W'(FRAMES);
        end else begin
            w_reset_lim = LIM_W'(lrupr_pkg::CFG_RESET);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= w_reset_lim;
        end else if (i_cfg_we) begin
            r_lim <= n_lim;
        end
    end

    // Handshake
    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    // Row of cells; cell 0 takes the new page
    assign w_above[0] = 1'b1;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g].valid = 1'b1;
            assign w_prev[g].page  = i_page_number;
        end else begin : g_body
            assign w_prev[g] = w_entry[g-1];
        end

        assign w_ctl[g].load   = w_accept;
        assign w_ctl[g].active = 32'(g) < 32'(r_lim);
        assign w_ctl[g].drop   = i_cfg_we && !(32'(g) < 32'(n_lim));

        lrupr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_page  (i_page_number),
            .i_prev  (w_prev[g]),
            .i_above (w_above[g]),
            .o_entry (w_entry[g]),
            .o_above (w_above[g+1])
        );
    end

    // Some cell matched when the chain comes out cleared
    assign w_hit = !w_above[FRAMES];

    // Result register and saturating totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_hits   <= '0;
            r_misses <= '0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
                if (w_hit) begin
                    if (r_hits != lrupr_pkg::CNT_MAX) begin
                        r_hits <= r_hits + 1'b1;
                    end
                end else begin
                    if (r_misses != lrupr_pkg::CNT_MAX) begin
                        r_misses <= r_misses + 1'b1;
                    end
                end
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_was_hit <= w_hit;
        end
    end

    assign o_valid      = r_valid;
    assign o_was_hit    = r_was_hit;
    assign o_hit_total  = r_hits;
    assign o_miss_total = r_misses;

endmodule
